// File: hdl/dsc_pkg.sv
// Shared types and constants of the box-average image downscaler.
// No dependencies; every other file of the block imports it.
package dsc_pkg;

   localparam int DEF_MAX_WIDTH  = 4096;
   localparam int DEF_MAX_HEIGHT = 4096;
   localparam int CHAN_W         = 8;
   localparam int CHAN_N         = 4;
   localparam int CFG_W          = 13;
   localparam int CSR_IDX_W      = 2;
   localparam int SUM_W          = 32;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type REG_SOURCE_WIDTH  = 2'd0;
   localparam csr_idx_type REG_SOURCE_HEIGHT = 2'd1;
   localparam csr_idx_type REG_TARGET_WIDTH  = 2'd2;
   localparam csr_idx_type REG_TARGET_HEIGHT = 2'd3;

   typedef logic [CHAN_N-1:0][CHAN_W-1:0] pix_type;

   typedef struct packed {
      logic restart;
   } dsc_ctrl_type;

   typedef struct packed {
      logic clear_busy;
   } dsc_stat_type;

endpackage

// File: hdl/dsc_if.sv
// Channel interfaces of the downscaler: pixel request, averaged response,
// register writes. Depends on dsc_pkg.
interface dsc_req_if import dsc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] pix_blue;
   logic [CHAN_W-1:0] pix_green;
   logic [CHAN_W-1:0] pix_red;
   logic [CHAN_W-1:0] pix_alpha;
   modport source (output valid, pix_blue, pix_green, pix_red, pix_alpha, input ready);
   modport sink (input valid, pix_blue, pix_green, pix_red, pix_alpha, output ready);
endinterface

interface dsc_rsp_if import dsc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] avg_blue;
   logic [CHAN_W-1:0] avg_green;
   logic [CHAN_W-1:0] avg_red;
   logic [CHAN_W-1:0] avg_alpha;
   logic              frame_done;
   modport source (output valid, avg_blue, avg_green, avg_red, avg_alpha, frame_done,
                   input ready);
   modport sink (input valid, avg_blue, avg_green, avg_red, avg_alpha, frame_done,
                 output ready);
endinterface

interface dsc_csr_if import dsc_pkg::*; ();
   logic             valid;
   logic             ready;
   csr_idx_type      index;
   logic [CFG_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/dsc_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on dsc_pkg only through the import convention.
module dsc_div import dsc_pkg::*; #(
   parameter int NW = 32,
   parameter int DW = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          busy,
   output logic [NW-1:0] quotient,
   output logic [DW-1:0] remainder
);
   localparam int CNW = $clog2(NW + 1);

   logic          busy_ff;
   logic [CNW-1:0] cnt_ff;
   logic [NW-1:0] quo_ff, quo_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] dvs_ff;
   logic [DW:0]   shifted, diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[NW-1]};
      diff    = shifted - {1'b0, dvs_ff};
      if (!diff[DW]) begin
         rem_in = diff[DW-1:0];
         quo_in = {quo_ff[NW-2:0], 1'b1};
      end else begin
         rem_in = shifted[DW-1:0];
         quo_in = {quo_ff[NW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNW'(NW);
         quo_ff  <= dividend;
         rem_ff  <= '0;
         dvs_ff  <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff - CNW'(1);
         if (cnt_ff == CNW'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule

// File: hdl/dsc_queue.sv
// Two-word queue between the front and back parts.
// Depends on dsc_pkg only through the import convention.
module dsc_queue import dsc_pkg::*; #(
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  logic [W-1:0] in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output logic [W-1:0] out_data
);
   logic [W-1:0] slot_ff [2];
   logic         wr_ptr_ff, rd_ptr_ff;
   logic [1:0]   cnt_ff;
   logic         push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end
endmodule

// File: hdl/dsc_front.sv
// Front part: register file, box boundary tracking and pixel classification.
// Depends on dsc_pkg, dsc_if and dsc_div.
module dsc_front import dsc_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   localparam int WW  = $clog2(MAX_WIDTH + 1),
   localparam int HW  = $clog2(MAX_HEIGHT + 1),
   localparam int CW  = $clog2(MAX_WIDTH),
   localparam int RW  = $clog2(MAX_HEIGHT),
   localparam int NW  = WW + HW,
   localparam int EW  = CHAN_N * CHAN_W + CW + 2 + NW
) (
   input  logic          clock,
   input  logic          reset,
   dsc_csr_if.sink       csr,
   dsc_req_if.sink       req,
   output logic          q_valid,
   input  logic          q_ready,
   output logic [EW-1:0] q_data,
   output dsc_ctrl_type  ctrl,
   input  dsc_stat_type  stat
);
   localparam int XW = (WW > CFG_W) ? WW : CFG_W;
   localparam int YW = (HW > CFG_W) ? HW : CFG_W;

   typedef struct packed {
      pix_type       pix;
      logic [CW-1:0] idx;
      logic          emit;
      logic          last;
      logic [NW-1:0] count;
   } entry_type;

   typedef enum logic [1:0] {SETUP, WAIT, RUN} state_type;

   state_type        state_ff;
   logic             restart_ff;
   logic [CFG_W-1:0] src_w_ff, src_h_ff, tgt_w_ff, tgt_h_ff;
   logic [WW-1:0]    sw_ff, tw_ff, col_q_ff, col_r_ff;
   logic [HW-1:0]    sh_ff, th_ff, row_q_ff, row_r_ff;
   logic [CW-1:0]    src_col_ff, tgt_col_ff;
   logic [RW-1:0]    src_row_ff, tgt_row_ff;
   logic [WW-1:0]    col_beg_ff, col_end_ff, col_rem_ff;
   logic [HW-1:0]    row_beg_ff, row_end_ff, row_rem_ff;

   logic [XW-1:0] sw_x, tw_x;
   logic [YW-1:0] sh_x, th_x;
   logic [WW-1:0] eff_sw, eff_tw, cq, cr;
   logic [HW-1:0] eff_sh, eff_th, rq, rr;
   logic          c_busy, r_busy, div_start, cfg_wr, accept;
   logic [WW-1:0] col_nxt, col_end_in, col_rem_in;
   logic [HW-1:0] row_nxt, row_end_in, row_rem_in;
   logic [WW:0]   col_sum;
   logic [HW:0]   row_sum;
   logic          col_last, row_last;
   entry_type     ent;

   assign csr.ready = 1'b1;
   assign cfg_wr    = csr.valid && csr.ready;
   assign div_start = (state_ff == SETUP);
   assign ctrl.restart = restart_ff;

   always_comb begin
      sw_x = XW'(src_w_ff);
      if (sw_x == '0) eff_sw = WW'(1);
      else if (sw_x > XW'(MAX_WIDTH)) eff_sw = WW'(MAX_WIDTH);
      else eff_sw = WW'(sw_x);
      tw_x = XW'(tgt_w_ff);
      if (tw_x == '0) eff_tw = WW'(1);
      else if (tw_x > XW'(eff_sw)) eff_tw = eff_sw;
      else eff_tw = WW'(tw_x);
      sh_x = YW'(src_h_ff);
      if (sh_x == '0) eff_sh = HW'(1);
      else if (sh_x > YW'(MAX_HEIGHT)) eff_sh = HW'(MAX_HEIGHT);
      else eff_sh = HW'(sh_x);
      th_x = YW'(tgt_h_ff);
      if (th_x == '0) eff_th = HW'(1);
      else if (th_x > YW'(eff_sh)) eff_th = eff_sh;
      else eff_th = HW'(th_x);
   end

   dsc_div #(.NW(WW), .DW(WW)) u_col_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(eff_sw),
      .divisor(eff_tw), .busy(c_busy), .quotient(cq), .remainder(cr)
   );

   dsc_div #(.NW(HW), .DW(HW)) u_row_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(eff_sh),
      .divisor(eff_th), .busy(r_busy), .quotient(rq), .remainder(rr)
   );

   assign req.ready = (state_ff == RUN) && !stat.clear_busy && q_ready;
   assign accept    = req.valid && req.ready;

   always_comb begin
      col_nxt  = WW'(src_col_ff) + WW'(1);
      row_nxt  = HW'(src_row_ff) + HW'(1);
      col_last = (col_nxt >= col_end_ff);
      row_last = (row_nxt >= row_end_ff);
      col_sum  = {1'b0, col_rem_ff} + {1'b0, col_r_ff};
      if (col_sum >= {1'b0, tw_ff}) begin
         col_rem_in = WW'(col_sum - {1'b0, tw_ff});
         col_end_in = col_end_ff + col_q_ff + WW'(1);
      end else begin
         col_rem_in = WW'(col_sum);
         col_end_in = col_end_ff + col_q_ff;
      end
      row_sum = {1'b0, row_rem_ff} + {1'b0, row_r_ff};
      if (row_sum >= {1'b0, th_ff}) begin
         row_rem_in = HW'(row_sum - {1'b0, th_ff});
         row_end_in = row_end_ff + row_q_ff + HW'(1);
      end else begin
         row_rem_in = HW'(row_sum);
         row_end_in = row_end_ff + row_q_ff;
      end
      ent.pix   = {req.pix_alpha, req.pix_red, req.pix_green, req.pix_blue};
      ent.idx   = tgt_col_ff;
      ent.emit  = col_last && row_last;
      ent.last  = (WW'(tgt_col_ff) + WW'(1) >= tw_ff) && (HW'(tgt_row_ff) + HW'(1) >= th_ff);
      ent.count = NW'(col_end_ff - col_beg_ff) * NW'(row_end_ff - row_beg_ff);
   end

   assign q_valid = accept;
   assign q_data  = ent;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= SETUP;
         restart_ff <= 1'b0;
         src_w_ff   <= CFG_W'(1);
         src_h_ff   <= CFG_W'(1);
         tgt_w_ff   <= CFG_W'(1);
         tgt_h_ff   <= CFG_W'(1);
         src_col_ff <= '0;
         src_row_ff <= '0;
         tgt_col_ff <= '0;
         tgt_row_ff <= '0;
      end else begin
         restart_ff <= cfg_wr;
         if (cfg_wr) begin
            unique case (csr.index)
               REG_SOURCE_WIDTH:  src_w_ff <= csr.data;
               REG_SOURCE_HEIGHT: src_h_ff <= csr.data;
               REG_TARGET_WIDTH:  tgt_w_ff <= csr.data;
               REG_TARGET_HEIGHT: tgt_h_ff <= csr.data;
               default: ;
            endcase
            state_ff <= SETUP;
         end else begin
            unique case (state_ff)
               SETUP: begin
                  sw_ff    <= eff_sw;
                  tw_ff    <= eff_tw;
                  sh_ff    <= eff_sh;
                  th_ff    <= eff_th;
                  state_ff <= WAIT;
               end
               WAIT: begin
                  if (!c_busy && !r_busy) begin
                     col_q_ff   <= cq;
                     col_r_ff   <= cr;
                     row_q_ff   <= rq;
                     row_r_ff   <= rr;
                     src_col_ff <= '0;
                     src_row_ff <= '0;
                     tgt_col_ff <= '0;
                     tgt_row_ff <= '0;
                     col_beg_ff <= '0;
                     col_end_ff <= cq;
                     col_rem_ff <= cr;
                     row_beg_ff <= '0;
                     row_end_ff <= rq;
                     row_rem_ff <= rr;
                     state_ff   <= RUN;
                  end
               end
               RUN: begin
                  if (accept) begin
                     if (col_nxt >= sw_ff) begin
                        src_col_ff <= '0;
                        tgt_col_ff <= '0;
                        col_beg_ff <= '0;
                        col_end_ff <= col_q_ff;
                        col_rem_ff <= col_r_ff;
                        if (row_nxt >= sh_ff) begin
                           src_row_ff <= '0;
                           tgt_row_ff <= '0;
                           row_beg_ff <= '0;
                           row_end_ff <= row_q_ff;
                           row_rem_ff <= row_r_ff;
                        end else begin
                           src_row_ff <= src_row_ff + RW'(1);
                           if (row_last) begin
                              tgt_row_ff <= tgt_row_ff + RW'(1);
                              row_beg_ff <= row_end_ff;
                              row_end_ff <= row_end_in;
                              row_rem_ff <= row_rem_in;
                           end
                        end
                     end else begin
                        src_col_ff <= src_col_ff + CW'(1);
                        if (col_last) begin
                           tgt_col_ff <= tgt_col_ff + CW'(1);
                           col_beg_ff <= col_end_ff;
                           col_end_ff <= col_end_in;
                           col_rem_ff <= col_rem_in;
                        end
                     end
                  end
               end
               default: state_ff <= SETUP;
            endcase
         end
      end
   end
endmodule

// File: hdl/dsc_back.sv
// Back part: accumulator row memory, box averaging and the response register.
// Depends on dsc_pkg, dsc_if and dsc_div.
module dsc_back import dsc_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   localparam int WW  = $clog2(MAX_WIDTH + 1),
   localparam int HW  = $clog2(MAX_HEIGHT + 1),
   localparam int CW  = $clog2(MAX_WIDTH),
   localparam int NW  = WW + HW,
   localparam int EW  = CHAN_N * CHAN_W + CW + 2 + NW
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          q_valid,
   output logic          q_ready,
   input  logic [EW-1:0] q_data,
   input  dsc_ctrl_type  ctrl,
   output dsc_stat_type  stat,
   dsc_rsp_if.source     rsp
);
   typedef struct packed {
      pix_type       pix;
      logic [CW-1:0] idx;
      logic          emit;
      logic          last;
      logic [NW-1:0] count;
   } entry_type;

   typedef logic [CHAN_N-1:0][SUM_W-1:0] acc_type;
   typedef enum logic [2:0] {CLEAR, IDLE, READ, ADD, DIV, OUT} state_type;

   acc_type       acc_mem [MAX_WIDTH];
   acc_type       rd_ff, sums;
   state_type     state_ff;
   entry_type     ent_ff;
   logic [CW-1:0] clr_addr_ff;
   pix_type       avg_ff;
   logic          last_ff;
   logic          we, div_start;
   logic [CW-1:0] wa;
   acc_type       wd;
   logic [CHAN_N-1:0]            busy;
   logic [CHAN_N-1:0][SUM_W-1:0] quo;
   logic [CHAN_N-1:0][NW-1:0]    rem;

   assign q_ready         = (state_ff == IDLE);
   assign stat.clear_busy = (state_ff == CLEAR);
   assign div_start       = (state_ff == ADD) && ent_ff.emit;

   always_comb begin
      for (int c = 0; c < CHAN_N; c++) begin
         sums[c] = rd_ff[c] + SUM_W'(ent_ff.pix[c]);
      end
      we = 1'b0;
      wa = ent_ff.idx;
      wd = '0;
      if (state_ff == CLEAR) begin
         we = 1'b1;
         wa = clr_addr_ff;
      end else if (state_ff == ADD) begin
         we = 1'b1;
         wd = ent_ff.emit ? '0 : sums;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         acc_mem[wa] <= wd;
      end
      rd_ff <= acc_mem[ent_ff.idx];
   end

   for (genvar c = 0; c < CHAN_N; c++) begin : g_div
      dsc_div #(.NW(SUM_W), .DW(NW)) u_div (
         .clock(clock), .reset(reset), .start(div_start), .dividend(sums[c]),
         .divisor(ent_ff.count), .busy(busy[c]), .quotient(quo[c]), .remainder(rem[c])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= CLEAR;
         clr_addr_ff <= '0;
      end else if (ctrl.restart) begin
         state_ff    <= CLEAR;
         clr_addr_ff <= '0;
      end else begin
         unique case (state_ff)
            CLEAR: begin
               clr_addr_ff <= clr_addr_ff + CW'(1);
               if (clr_addr_ff == CW'(MAX_WIDTH - 1)) state_ff <= IDLE;
            end
            IDLE: begin
               if (q_valid) begin
                  ent_ff   <= q_data;
                  state_ff <= READ;
               end
            end
            READ: state_ff <= ADD;
            ADD: state_ff <= ent_ff.emit ? DIV : IDLE;
            DIV: begin
               if (busy == '0) begin
                  for (int c = 0; c < CHAN_N; c++) begin
                     avg_ff[c] <= quo[c][CHAN_W-1:0];
                  end
                  last_ff  <= ent_ff.last;
                  state_ff <= OUT;
               end
            end
            OUT: begin
               if (rsp.ready) state_ff <= IDLE;
            end
            default: state_ff <= CLEAR;
         endcase
      end
   end

   assign rsp.valid      = (state_ff == OUT);
   assign rsp.avg_blue   = avg_ff[0];
   assign rsp.avg_green  = avg_ff[1];
   assign rsp.avg_red    = avg_ff[2];
   assign rsp.avg_alpha  = avg_ff[3];
   assign rsp.frame_done = last_ff;
endmodule

// File: hdl/box_average_image_downscaler.sv
// Top level of the box-average image downscaler: front, queue and back.
// Depends on dsc_pkg, dsc_if, dsc_front, dsc_queue, dsc_back.
//
//   channel  dir  handshake      word
//   req      in   valid/ready    pix_blue, pix_green, pix_red, pix_alpha
//   rsp      out  valid/ready    avg_blue, avg_green, avg_red, avg_alpha, frame_done
//   csr      in   valid/ready    index (2 bits), data (13 bits)
//
// A pixel with no result passes the READ and ADD states of the back part; a pixel
// that closes a box also waits in DIV for the bit-serial 32-bit divider and in OUT,
// the response register, for any rsp stall.
// The front accepts up to two pixels ahead through the queue.
// After reset and after every csr write, the accumulator row is cleared address by
// address and the box steps are computed anew by the dividers; req.ready stays low meanwhile.
module box_average_image_downscaler import dsc_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input logic       clock,
   input logic       reset,
   dsc_req_if.sink   req,
   dsc_rsp_if.source rsp,
   dsc_csr_if.sink   csr
);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int EW = CHAN_N * CHAN_W + CW + 2 + WW + HW;

   logic          fq_valid, fq_ready, qb_valid, qb_ready;
   logic [EW-1:0] fq_data, qb_data;
   dsc_ctrl_type  ctrl;
   dsc_stat_type  stat;

   dsc_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
      .clock(clock), .reset(reset), .csr(csr), .req(req),
      .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data),
      .ctrl(ctrl), .stat(stat)
   );

   dsc_queue #(.W(EW)) u_queue (
      .clock(clock), .reset(reset),
      .in_valid(fq_valid), .in_ready(fq_ready), .in_data(fq_data),
      .out_valid(qb_valid), .out_ready(qb_ready), .out_data(qb_data)
   );

   dsc_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
      .clock(clock), .reset(reset),
      .q_valid(qb_valid), .q_ready(qb_ready), .q_data(qb_data),
      .ctrl(ctrl), .stat(stat), .rsp(rsp)
   );
endmodule
